@@ hw/rtl/gf256_lagrange_secret_recover_defines.svh @@
// Assertion macros for the GF(256) secret recovery block.
// Standalone header; expects a clock named clk and a reset named rst in scope.
`ifndef GF256_LAGRANGE_SECRET_RECOVER_DEFINES_SVH
`define GF256_LAGRANGE_SECRET_RECOVER_DEFINES_SVH

// same-cycle implication
`define GLSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/glsr_pkg.sv @@
// Types, constants and the GF(2^8) multiply for the secret recovery block.
// No dependencies.
package glsr_pkg;

  localparam int MAX_SHARES_DEF = 16;

  // b^254 takes seven square-and-multiply steps
  localparam logic [2:0] INV_LAST = 3'd6;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_DUP = 2'd1,
    STATUS_OVF = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LDJ,
    ST_LATJ,
    ST_MNUM,
    ST_MDEN,
    ST_INV_SQ,
    ST_INV_MUL,
    ST_TERM1,
    ST_TERM2,
    ST_OUT
  } state_t;

  // carry-less multiply reduced by x^8 + x^4 + x^3 + x + 1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    logic       carry;
    acc = 8'h00;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= aa;
      carry = aa[7];
      aa = {aa[6:0], 1'b0};
      if (carry) aa ^= 8'h1B;
    end
    return acc;
  endfunction

endpackage

@@ hw/rtl/gf256_lagrange_secret_recover.sv @@
// GF(256) Shamir secret recovery: point store plus Lagrange interpolation at zero.
// Uses glsr_pkg and gf256_lagrange_secret_recover_defines.svh.
// A share that is not final leaves the block ready for the next. A final share with n stored
// shares gives a valid result on one shared GF multiplier: per j, load, the products, the
// inversion, then the term. Overflow goes straight to the result; a duplicate ends sooner.
// Synchronous active-high reset empties the store; ready again once the result is taken.
`include "gf256_lagrange_secret_recover_defines.svh"

module gf256_lagrange_secret_recover #(
  parameter int MAX_SHARES = glsr_pkg::MAX_SHARES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] share_x,
  input  logic [7:0] share_y,
  input  logic       final_share,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] secret_byte,
  output logic [1:0] status
);

  localparam int IDX_W = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
  localparam int CNT_W = $clog2(MAX_SHARES + 1);

  glsr_pkg::state_t  state;
  glsr_pkg::state_t  state_next;
  logic [CNT_W-1:0]  share_count;
  logic [CNT_W-1:0]  share_count_next;
  logic              overflow_seen;
  logic              overflow_seen_next;

  logic [7:0]        x_mem [MAX_SHARES];
  logic [7:0]        y_mem [MAX_SHARES];
  logic [7:0]        x_q;
  logic [7:0]        y_q;
  logic [IDX_W-1:0]  rd_addr;

  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  m;
  logic [7:0]        xj;
  logic [7:0]        yj;
  logic [7:0]        num;
  logic [7:0]        den;
  logic [7:0]        inv_r;
  logic [2:0]        k;
  logic [7:0]        acc;
  glsr_pkg::status_t status_q;

  logic [7:0]        mul_a;
  logic [7:0]        mul_b;
  logic [7:0]        mul_p;

  logic              in_acc;
  logic              has_room;
  logic              last_m;
  logic              last_j;
  logic              skip_m;
  logic              dup_hit;

  assign in_acc   = in_valid && in_ready;
  assign has_room = share_count < CNT_W'(MAX_SHARES);
  assign last_m   = (CNT_W'(m) + CNT_W'(1)) == share_count;
  assign last_j   = (CNT_W'(j) + CNT_W'(1)) == share_count;
  assign skip_m   = (m == j);
  assign dup_hit  = !skip_m && (x_q == xj);
  assign mul_p    = glsr_pkg::gf_mul(mul_a, mul_b);

  assign secret_byte = acc;
  assign status      = status_q;

  // next state and control counters
  always_comb begin
    state_next         = state;
    share_count_next   = share_count;
    overflow_seen_next = overflow_seen;
    unique case (state)
      glsr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (has_room) share_count_next = share_count + CNT_W'(1);
          else          overflow_seen_next = 1'b1;
          if (final_share) begin
            state_next = (overflow_seen || !has_room) ? glsr_pkg::ST_OUT
                                                      : glsr_pkg::ST_LDJ;
          end
        end
      end
      glsr_pkg::ST_LDJ:  state_next = glsr_pkg::ST_LATJ;
      glsr_pkg::ST_LATJ: state_next = glsr_pkg::ST_MNUM;
      glsr_pkg::ST_MNUM: state_next = dup_hit ? glsr_pkg::ST_OUT : glsr_pkg::ST_MDEN;
      glsr_pkg::ST_MDEN: state_next = last_m ? glsr_pkg::ST_INV_SQ : glsr_pkg::ST_MNUM;
      glsr_pkg::ST_INV_SQ: state_next = glsr_pkg::ST_INV_MUL;
      glsr_pkg::ST_INV_MUL: begin
        state_next = (k == glsr_pkg::INV_LAST) ? glsr_pkg::ST_TERM1 : glsr_pkg::ST_INV_SQ;
      end
      glsr_pkg::ST_TERM1: state_next = glsr_pkg::ST_TERM2;
      glsr_pkg::ST_TERM2: state_next = last_j ? glsr_pkg::ST_OUT : glsr_pkg::ST_LDJ;
      glsr_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next         = glsr_pkg::ST_IDLE;
          share_count_next   = '0;
          overflow_seen_next = 1'b0;
        end
      end
      default: state_next = glsr_pkg::ST_IDLE;
    endcase
  end

  // handshake, read address and multiplier operand select
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_addr   = m;
    mul_a     = 8'h00;
    mul_b     = 8'h00;
    unique case (state)
      glsr_pkg::ST_IDLE:    in_ready = 1'b1;
      glsr_pkg::ST_LDJ:     rd_addr = j;
      glsr_pkg::ST_LATJ:    rd_addr = m;
      glsr_pkg::ST_MNUM: begin
        mul_a = num;
        mul_b = x_q;
      end
      glsr_pkg::ST_MDEN: begin
        rd_addr = m + IDX_W'(1);
        mul_a   = den;
        mul_b   = xj ^ x_q;
      end
      glsr_pkg::ST_INV_SQ: begin
        mul_a = den;
        mul_b = den;
      end
      glsr_pkg::ST_INV_MUL: begin
        mul_a = inv_r;
        mul_b = den;
      end
      glsr_pkg::ST_TERM1: begin
        mul_a = num;
        mul_b = inv_r;
      end
      glsr_pkg::ST_TERM2: begin
        mul_a = yj;
        mul_b = num;
      end
      glsr_pkg::ST_OUT:     out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= glsr_pkg::ST_IDLE;
      share_count   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      share_count   <= share_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      x_mem[share_count[IDX_W-1:0]] <= share_x;
      y_mem[share_count[IDX_W-1:0]] <= share_y;
    end
    x_q <= x_mem[rd_addr];
    y_q <= y_mem[rd_addr];
  end

  // interpolation datapath
  always_ff @(posedge clk) begin
    unique case (state)
      glsr_pkg::ST_IDLE: begin
        if (in_acc && final_share) begin
          j        <= '0;
          acc      <= 8'h00;
          status_q <= (overflow_seen || !has_room) ? glsr_pkg::STATUS_OVF
                                                   : glsr_pkg::STATUS_OK;
        end
      end
      glsr_pkg::ST_LDJ: m <= '0;
      glsr_pkg::ST_LATJ: begin
        xj    <= x_q;
        yj    <= y_q;
        num   <= 8'h01;
        den   <= 8'h01;
        inv_r <= 8'h01;
        k     <= '0;
      end
      glsr_pkg::ST_MNUM: begin
        if (!skip_m) num <= mul_p;
        if (dup_hit) begin
          status_q <= glsr_pkg::STATUS_DUP;
          acc      <= 8'h00;
        end
      end
      glsr_pkg::ST_MDEN: begin
        if (!skip_m) den <= mul_p;
        m <= m + IDX_W'(1);
      end
      glsr_pkg::ST_INV_SQ: den <= mul_p;
      glsr_pkg::ST_INV_MUL: begin
        inv_r <= mul_p;
        k     <= k + 3'd1;
      end
      glsr_pkg::ST_TERM1: num <= mul_p;
      glsr_pkg::ST_TERM2: begin
        acc <= acc ^ mul_p;
        j   <= j + IDX_W'(1);
      end
      glsr_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  `GLSR_ASSERT_NOW(a_ready_excl, in_ready, !out_valid, "input ready while result pending")
  `GLSR_ASSERT_NOW(a_err_zero, out_valid && (status != glsr_pkg::STATUS_OK),
    secret_byte == 8'h00, "error result with nonzero secret")
  `GLSR_ASSERT_NOW(a_count_max, 1'b1, share_count <= CNT_W'(MAX_SHARES),
    "share count beyond capacity")
  `GLSR_ASSERT_NEXT(a_final_busy, in_valid && in_ready && final_share, !in_ready,
    "ready right after final share")
  `GLSR_ASSERT_NEXT(a_out_done, out_valid && out_ready, in_ready && (share_count == '0),
    "store not emptied after result")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for gf256_lagrange_secret_recover: share sets in, secrets out.
// Depends on glsr_pkg for the status codes and the store depth.

module testbench;

  localparam int SHARE_CAP      = glsr_pkg::MAX_SHARES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [7:0]          secret;
    glsr_pkg::status_t   code;
  } recovery_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] share_x     = 8'h00;
  logic [7:0] share_y     = 8'h00;
  logic       final_share = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] secret_byte;
  logic [1:0] status;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count     = 0;
  int idle_cycles   = 0;

  // mirror of the point store
  logic [7:0] x_mem [SHARE_CAP];
  logic [7:0] y_mem [SHARE_CAP];
  int         shares_held    = 0;
  logic       store_overflow = 1'b0;
  logic [7:0] recip_tab [256];

  recovery_t  pending_recoveries [$];

  gf256_lagrange_secret_recover #(.MAX_SHARES(SHARE_CAP)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .share_x     (share_x),
    .share_y     (share_y),
    .final_share (final_share),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .secret_byte (secret_byte),
    .status      (status)
  );

  always #5 clk = ~clk;

  // Horner form: shift-and-reduce, then add a when the bit of b is set
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1B : 8'h00);
      if (b[i]) acc ^= a;
    end
    return acc;
  endfunction

  function automatic logic [7:0] secret_from_store();
    logic [7:0] sum;
    logic [7:0] weight;
    sum = 8'h00;
    for (int j = 0; j < shares_held; j++) begin
      weight = 8'h01;
      for (int m = 0; m < shares_held; m++) begin
        if (m != j)
          weight = gf_times(gf_times(weight, x_mem[m]), recip_tab[x_mem[j] ^ x_mem[m]]);
      end
      sum ^= gf_times(y_mem[j], weight);
    end
    return sum;
  endfunction

  task automatic record_share(input logic [7:0] x, input logic [7:0] y, input logic fin);
    recovery_t r;
    if (shares_held < SHARE_CAP) begin
      x_mem[shares_held] = x;
      y_mem[shares_held] = y;
      shares_held++;
    end else begin
      store_overflow = 1'b1;
    end
    if (fin) begin
      r.code = glsr_pkg::STATUS_OK;
      if (store_overflow) begin
        r.code = glsr_pkg::STATUS_OVF;
      end else begin
        for (int j = 0; j < shares_held; j++)
          for (int m = j + 1; m < shares_held; m++)
            if (x_mem[j] == x_mem[m]) r.code = glsr_pkg::STATUS_DUP;
      end
      r.secret = (r.code == glsr_pkg::STATUS_OK) ? secret_from_store() : 8'h00;
      pending_recoveries.push_back(r);
      shares_held    = 0;
      store_overflow = 1'b0;
    end
  endtask

  task automatic log_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // called and returns at a falling edge; valid stays high for a back-to-back transaction
  task automatic send_share(input logic [7:0] x, input logic [7:0] y, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    share_x     <= x;
    share_y     <= y;
    final_share <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_share(x, y, fin);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_recoveries.size() != 0) @(negedge clk);
  endtask

  task automatic test_edge_cases();
    send_share(8'h00, 8'hFF, 1'b1);
    send_share(8'h00, 8'h00, 1'b0);
    send_share(8'hFF, 8'hFF, 1'b1);
    send_share(8'h5A, 8'h12, 1'b0);
    send_share(8'h5A, 8'h34, 1'b1);
    // overflow with duplicates inside: overflow wins
    for (int i = 0; i <= SHARE_CAP; i++)
      send_share(8'(i % 8), 8'(255 - i), i == SHARE_CAP);
    wait_results_drained();
  endtask

  task automatic test_random_sets(input int n_items, input int s_pct, input int r_pct);
    logic [7:0]   xs [SHARE_CAP + 4];
    logic [255:0] used;
    int           sent;
    int           kind;
    int           set_len;
    int           k;
    sent          = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 80)      set_len = $urandom_range(1, 6);
      else if (kind < 88) set_len = $urandom_range(7, SHARE_CAP);
      else if (kind < 94) set_len = $urandom_range(2, 8);
      else                set_len = $urandom_range(SHARE_CAP + 1, SHARE_CAP + 4);
      used = '0;
      for (int i = 0; i < set_len; i++) begin
        xs[i] = 8'($urandom_range(255));
        if (kind < 94)
          while (used[xs[i]]) xs[i] = 8'($urandom_range(255));
        used[xs[i]] = 1'b1;
      end
      if (kind >= 88 && kind < 94) begin
        k = $urandom_range(1, set_len - 1);
        xs[k] = xs[$urandom_range(0, k - 1)];
      end
      for (int i = 0; i < set_len; i++)
        send_share(xs[i], 8'($urandom_range(255)), i == set_len - 1);
      sent += set_len;
      if ($urandom_range(19) == 0) wait_results_drained();
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    recovery_t r;
    if (!rst && out_valid && out_ready) begin
      if (pending_recoveries.size() == 0) begin
        log_mismatch($sformatf("unexpected result secret=%02h status=%0d",
                               secret_byte, status));
      end else begin
        r = pending_recoveries.pop_front();
        if (secret_byte !== r.secret)
          log_mismatch($sformatf("secret_byte exp %02h got %02h", r.secret, secret_byte));
        if (status !== r.code)
          log_mismatch($sformatf("status exp %0d got %0d", r.code, status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    recip_tab[0] = 8'h00;
    for (int a = 1; a < 256; a++)
      for (int c = 1; c < 256; c++)
        if (gf_times(8'(a), 8'(c)) == 8'h01) recip_tab[a] = 8'(c);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_random_sets(700, 6, 60);
    test_random_sets(700, 60, 6);
    test_random_sets(600, 0, 0);

    in_valid <= 1'b0;
    while (pending_recoveries.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_recoveries.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_recoveries.size()));

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
